FILE: src/edge_point_subdivider_defines.svh
// Assertion helpers used by the checked module.
`ifndef EDGE_POINT_SUBDIVIDER_DEFINES_SVH
`define EDGE_POINT_SUBDIVIDER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define EPS_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define EPS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/eps_pkg.sv
package eps_pkg;

    // shared divider: 35-bit dividend, 32-bit divisor
    localparam int DIV_DW = 35;
    localparam int DIV_VW = 32;

    // register index of spacing
    localparam logic ADDR_SPACING = 1'b0;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } div_in_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quo;
        logic [DIV_VW-1:0] rem;
    } div_out_t;

endpackage

FILE: src/eps_div.sv
module eps_div
(
    input  logic            clk,
    input  logic            rst_n,
    input  eps_pkg::div_in_t  div_in,
    output eps_pkg::div_out_t div_out
);

    localparam int DW = eps_pkg::DIV_DW;
    localparam int VW = eps_pkg::DIV_VW;

    logic          busy_reg;
    logic          done_reg;
    logic [5:0]    cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;

    logic [VW:0]   trial;
    logic          take;
    logic [VW:0]   diff;
    logic          step_last;

    // restoring division, one quotient bit a cycle
    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign take      = trial >= {1'b0, dvs_reg};
    assign diff      = trial - {1'b0, dvs_reg};
    assign step_last = busy_reg && (cnt_reg == 6'(DW - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= step_last;
            if (div_in.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (step_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_in.start)
        begin
            quo_reg <= div_in.dividend;
            rem_reg <= '0;
            dvs_reg <= div_in.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], take};
            rem_reg <= take ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign div_out.done = done_reg;
    assign div_out.quo  = quo_reg;
    assign div_out.rem  = rem_reg;

endmodule

FILE: src/edge_point_subdivider.sv
// Edge point subdivider.
// Input channel (in_valid/in_ready) takes one word per edge: two 3D endpoints,
// signed fixed point. Output channel (out_valid/out_ready) returns one word per
// interior point, last set on the final word of the edge; an edge too short for
// any point returns one word with point_valid low and last high.
// spacing must be written over the APB port while the block is idle; not enforced.
// Per edge: shift-add squaring (three axes), digit-by-digit square root, one
// division for the count and three divisions for the per-axis steps, all on
// one adder datapath and one shared divider; then one point per cycle while
// the receiver takes them. in_ready is high only while the sequencer is
// idle, so one edge is in work at a time.
// Points are stepped with an add and one compare-subtract per axis.
// A stalled receiver holds the output register; point generation waits and
// nothing is dropped. The next edge may be accepted while the last word waits.
// Reset empties the sequencer and output register and sets spacing to 1.0.
`include "edge_point_subdivider_defines.svh"

module edge_point_subdivider
#(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic [5:0]         point_index,
    output logic [6:0]         point_count,
    output logic               point_valid,
    output logic               count_saturated,
    output logic               last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = $clog2(MAX_POINTS + 2);
    localparam int RW = CW + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_CDIV = 3'd3;
    localparam logic [2:0] ST_ADIV = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]    state_reg;
    logic [5:0]    cnt_reg;
    logic [1:0]    k_reg;
    logic          start_reg;
    logic [NW-1:0] idx_reg;
    logic          out_valid_reg;
    logic [30:0]   spacing_reg;

    logic [31:0]   a_reg [3];
    logic          neg_reg [3];
    logic [32:0]   mag_reg [3];
    logic [65:0]   sum_reg;
    logic [65:0]   mcand_reg;
    logic [32:0]   mplier_reg;
    logic [32:0]   root_reg;
    logic [34:0]   srem_reg;
    logic [NW-1:0] n_reg;
    logic          sat_reg;
    logic [CW-1:0] den_reg;
    logic [32:0]   qstep_reg [3];
    logic [RW-1:0] rstep_reg [3];
    logic [32:0]   q_reg [3];
    logic [RW-1:0] racc_reg [3];

    logic [31:0]   px_reg, py_reg, pz_reg;
    logic [5:0]    pidx_reg;
    logic [6:0]    pcnt_reg;
    logic          pvalid_reg, psat_reg, plast_reg;

    logic [32:0]   q_next [3];
    logic [RW-1:0] racc_next [3];
    logic [31:0]   pt_next [3];

    logic [31:0]   in_s [3];
    logic [31:0]   in_e [3];
    logic [32:0]   dif [3];
    logic [32:0]   dmag [3];

    eps_pkg::div_in_t  div_in;
    eps_pkg::div_out_t div_out;

    logic          acc_in;
    logic          mul_last;
    logic          sqrt_last;
    logic          fire;
    logic          emit_last;
    logic          cfg_wr;
    logic [30:0]   sp;
    logic [36:0]   rt;
    logic [36:0]   trial;
    logic          rt_ge;
    logic [34:0]   nraw;
    logic          nsat;
    logic [NW-1:0] nsel;
    logic [RW-1:0] twoden;

    assign in_s[0] = start_x;
    assign in_s[1] = start_y;
    assign in_s[2] = start_z;
    assign in_e[0] = end_x;
    assign in_e[1] = end_y;
    assign in_e[2] = end_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dif[i]  = {in_e[i][31], in_e[i]} - {in_s[i][31], in_s[i]};
            dmag[i] = dif[i][32] ? (33'd0 - dif[i]) : dif[i];
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign acc_in    = in_valid && in_ready;
    assign mul_last  = (state_reg == ST_MUL) && (cnt_reg == 6'd32);
    assign sqrt_last = (state_reg == ST_SQRT) && (cnt_reg == 6'd32);
    assign fire      = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign emit_last = (n_reg == '0) || (idx_reg == n_reg - NW'(1));
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign sp        = (spacing_reg == '0) ? 31'd1 : spacing_reg;

    // square root digit: bring down two bits, try (4*root + 1)
    assign rt    = {srem_reg, sum_reg[65:64]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign rt_ge = rt >= trial;

    // rounded count from the shared divider
    assign nraw   = div_out.quo;
    assign nsat   = nraw > 35'(MAX_POINTS);
    assign nsel   = nsat ? NW'(MAX_POINTS) : nraw[NW-1:0];
    assign twoden = {1'b0, den_reg, 1'b0};

    always_comb
    begin
        div_in.start = start_reg;
        if (state_reg == ST_CDIV)
        begin
            div_in.dividend = 35'({root_reg, 1'b0}) + 35'(sp);
            div_in.divisor  = {sp, 1'b0};
        end
        else
        begin
            div_in.dividend = 35'(mag_reg[k_reg]);
            div_in.divisor  = 32'(den_reg);
        end
    end

    eps_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_in  (div_in),
        .div_out (div_out)
    );

    // point i: quotient and remainder of (2*mag*i + den) / (2*den), stepped
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            racc_next[i] = racc_reg[i] + rstep_reg[i];
            q_next[i]    = q_reg[i] + qstep_reg[i];
            if (racc_next[i] >= twoden)
            begin
                racc_next[i] = racc_next[i] - twoden;
                q_next[i]    = q_next[i] + 33'd1;
            end
            pt_next[i] = neg_reg[i] ? (a_reg[i] - q_next[i][31:0])
                                    : (a_reg[i] + q_next[i][31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            start_reg     <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            spacing_reg   <= 31'(1) << FRAC_BITS;
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_wr && (paddr[2] == eps_pkg::ADDR_SPACING))
            begin
                spacing_reg <= pwdata[30:0];
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (acc_in)
                    begin
                        state_reg <= ST_MUL;
                        cnt_reg   <= '0;
                        k_reg     <= '0;
                    end
                end
                ST_MUL:
                begin
                    if (mul_last)
                    begin
                        cnt_reg <= '0;
                        if (k_reg == 2'd2)
                        begin
                            state_reg <= ST_SQRT;
                        end
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                ST_SQRT:
                begin
                    if (sqrt_last)
                    begin
                        state_reg <= ST_CDIV;
                        start_reg <= 1'b1;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                ST_CDIV:
                begin
                    if (div_out.done)
                    begin
                        k_reg   <= '0;
                        idx_reg <= '0;
                        if (nsel == '0)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            state_reg <= ST_ADIV;
                            start_reg <= 1'b1;
                        end
                    end
                end
                ST_ADIV:
                begin
                    if (div_out.done)
                    begin
                        if (k_reg == 2'd2)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 2'd1;
                            start_reg <= 1'b1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (fire)
                    begin
                        out_valid_reg <= 1'b1;
                        idx_reg       <= idx_reg + NW'(1);
                        if (emit_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i]   <= in_s[i];
                neg_reg[i] <= dif[i][32];
                mag_reg[i] <= dmag[i];
            end
            sum_reg    <= '0;
            mcand_reg  <= {33'd0, dmag[0]};
            mplier_reg <= dmag[0];
            root_reg   <= '0;
            srem_reg   <= '0;
        end

        if (state_reg == ST_MUL)
        begin
            if (mplier_reg[0])
            begin
                sum_reg <= sum_reg + mcand_reg;
            end
            if (mul_last)
            begin
                mcand_reg  <= {33'd0, mag_reg[k_reg + 2'd1]};
                mplier_reg <= mag_reg[k_reg + 2'd1];
            end
            else
            begin
                mcand_reg  <= {mcand_reg[64:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[32:1]};
            end
        end

        if (state_reg == ST_SQRT)
        begin
            sum_reg <= {sum_reg[63:0], 2'b00};
            if (rt_ge)
            begin
                srem_reg <= 35'(rt - trial);
                root_reg <= {root_reg[31:0], 1'b1};
            end
            else
            begin
                srem_reg <= rt[34:0];
                root_reg <= {root_reg[31:0], 1'b0};
            end
        end

        if ((state_reg == ST_CDIV) && div_out.done)
        begin
            n_reg   <= nsel;
            sat_reg <= nsat;
            den_reg <= CW'(nsel) + CW'(1);
        end

        if ((state_reg == ST_ADIV) && div_out.done)
        begin
            qstep_reg[k_reg] <= div_out.quo[32:0];
            rstep_reg[k_reg] <= RW'({div_out.rem[CW-1:0], 1'b0});
            q_reg[k_reg]     <= '0;
            racc_reg[k_reg]  <= RW'(den_reg);
        end

        if (fire)
        begin
            if (n_reg == '0)
            begin
                px_reg     <= '0;
                py_reg     <= '0;
                pz_reg     <= '0;
                pidx_reg   <= '0;
                pcnt_reg   <= '0;
                pvalid_reg <= 1'b0;
                psat_reg   <= 1'b0;
                plast_reg  <= 1'b1;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q_reg[i]    <= q_next[i];
                    racc_reg[i] <= racc_next[i];
                end
                px_reg     <= pt_next[0];
                py_reg     <= pt_next[1];
                pz_reg     <= pt_next[2];
                pidx_reg   <= 6'(idx_reg);
                pcnt_reg   <= 7'(n_reg);
                pvalid_reg <= 1'b1;
                psat_reg   <= sat_reg;
                plast_reg  <= emit_last;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign point_x         = px_reg;
    assign point_y         = py_reg;
    assign point_z         = pz_reg;
    assign point_index     = pidx_reg;
    assign point_count     = pcnt_reg;
    assign point_valid     = pvalid_reg;
    assign count_saturated = psat_reg;
    assign last            = plast_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == eps_pkg::ADDR_SPACING) ? {1'b0, spacing_reg} : 32'd0;

    `EPS_CHECK(a_sat_count, (state_reg == ST_EMIT) && sat_reg, n_reg == NW'(MAX_POINTS), "saturated count not clipped")
    `EPS_CHECK(a_emit_idx, state_reg == ST_EMIT, (idx_reg < n_reg) || (n_reg == '0), "point index past count")
    `EPS_CHECK(a_div_state, div_out.done, (state_reg == ST_CDIV) || (state_reg == ST_ADIV), "divider finished outside a divide step")
    `EPS_CHECK_NEXT(a_div_start, start_reg, !div_out.done, "divider finished right after start")

endmodule
